### hdl/qry_pkg.sv
// Shared types, widths and the arctangent table for the relative yaw pipeline.
`timescale 1ns / 1ps

package qry_pkg;

    localparam int QW             = 16;  // quaternion part, Q1.15
    localparam int TimeW          = 32;
    localparam int ProdW          = 2 * QW;
    localparam int VecW           = 36;  // horizontal axis, Q3.30 plus CORDIC growth
    localparam int AccW           = 32;  // binary angle accumulator
    localparam int HeadW          = 16;
    localparam int TurnW          = 14;
    localparam int MagW           = HeadW + 1;
    localparam int ScaleW         = 22;
    localparam int AtanLen        = 24;
    localparam int CordicStepsDef = 16;

    localparam logic signed [VecW-1:0] UnitX     = VecW'(2 ** 30);
    localparam logic [AccW-1:0]        HalfTurn  = 32'h8000_0000;
    localparam logic [AccW-1:0]        RoundHead = 32'h0000_8000;
    localparam logic [MagW-1:0]        FullTurn  = 17'h1_0000;
    localparam logic [ScaleW-1:0]      DegScale  = 22'd45;
    localparam logic [ScaleW-1:0]      RoundTurn = 22'd64;
    localparam int                     TurnShift = 7;
    localparam logic [TurnW-1:0]       TurnMax   = 14'd11520;

    // Sideband that travels with each beat through the pipeline.
    typedef struct packed {
        logic             valid;
        logic             set_ref;
        logic [TimeW-1:0] time_us;
    } qry_side_t;

    // CORDIC working vector and angle.
    typedef struct packed {
        logic                   zero;
        logic signed [VecW-1:0] x;
        logic signed [VecW-1:0] y;
        logic [AccW-1:0]        acc;
    } qry_vec_t;

    // atan(2^-i) on a 2^32 = 360 degree scale.
    function automatic logic [AccW-1:0] atan_entry(input int idx);
        logic [AccW-1:0] val;
        case (idx)
            0:       val = 32'h2000_0000;
            1:       val = 32'h12E4_051E;
            2:       val = 32'h09FB_385B;
            3:       val = 32'h0511_11D4;
            4:       val = 32'h028B_0D43;
            5:       val = 32'h0145_D7E1;
            6:       val = 32'h00A2_F61E;
            7:       val = 32'h0051_7C55;
            8:       val = 32'h0028_BE53;
            9:       val = 32'h0014_5F2F;
            10:      val = 32'h000A_2F98;
            11:      val = 32'h0005_17CC;
            12:      val = 32'h0002_8BE6;
            13:      val = 32'h0001_45F3;
            14:      val = 32'h0000_A2FA;
            15:      val = 32'h0000_517D;
            16:      val = 32'h0000_28BE;
            17:      val = 32'h0000_145F;
            18:      val = 32'h0000_0A30;
            19:      val = 32'h0000_0518;
            20:      val = 32'h0000_028C;
            21:      val = 32'h0000_0146;
            22:      val = 32'h0000_00A3;
            23:      val = 32'h0000_0051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

### hdl/qry_axis.sv
// World-frame body X axis: products, then sums and half-plane fold.
`timescale 1ns / 1ps

module qry_axis (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic signed [qry_pkg::QW-1:0]    q_w,
    input  logic signed [qry_pkg::QW-1:0]    q_x,
    input  logic signed [qry_pkg::QW-1:0]    q_y,
    input  logic signed [qry_pkg::QW-1:0]    q_z,
    input  qry_pkg::qry_side_t               side_in,
    output qry_pkg::qry_vec_t                vec_out,
    output qry_pkg::qry_side_t               side_out
);
    import qry_pkg::*;

    logic signed [ProdW-1:0] p_yy_reg, p_zz_reg, p_xy_reg, p_wz_reg;
    logic signed [ProdW-1:0] p_yy_next, p_zz_next, p_xy_next, p_wz_next;
    qry_side_t               side_a_reg, side_b_reg;
    qry_vec_t                vec_reg, vec_next;

    logic signed [VecW-1:0]  yy_e, zz_e, xy_e, wz_e, hx, hy;

    assign p_yy_next = q_y * q_y;
    assign p_zz_next = q_z * q_z;
    assign p_xy_next = q_x * q_y;
    assign p_wz_next = q_w * q_z;

    assign yy_e = {{(VecW-ProdW){p_yy_reg[ProdW-1]}}, p_yy_reg};
    assign zz_e = {{(VecW-ProdW){p_zz_reg[ProdW-1]}}, p_zz_reg};
    assign xy_e = {{(VecW-ProdW){p_xy_reg[ProdW-1]}}, p_xy_reg};
    assign wz_e = {{(VecW-ProdW){p_wz_reg[ProdW-1]}}, p_wz_reg};

    always_comb
    begin
        hx = UnitX - ((yy_e + zz_e) <<< 1);
        hy = (xy_e + wz_e) <<< 1;
        vec_next.zero = (hx == '0) && (hy == '0);
        // Fold the left half plane onto the right and start half a turn ahead.
        if (hx[VecW-1])
        begin
            vec_next.x   = -hx;
            vec_next.y   = -hy;
            vec_next.acc = HalfTurn;
        end
        else
        begin
            vec_next.x   = hx;
            vec_next.y   = hy;
            vec_next.acc = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a_reg <= '0;
            side_b_reg <= '0;
        end
        else if (adv)
        begin
            side_a_reg <= side_in;
            side_b_reg <= side_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_yy_reg <= p_yy_next;
            p_zz_reg <= p_zz_next;
            p_xy_reg <= p_xy_next;
            p_wz_reg <= p_wz_next;
            vec_reg  <= vec_next;
        end
    end

    assign vec_out  = vec_reg;
    assign side_out = side_b_reg;

endmodule

### hdl/qry_cordic.sv
// Vectoring CORDIC, one registered stage per iteration.
`timescale 1ns / 1ps

module qry_cordic #(
    parameter int CORDIC_STEPS = qry_pkg::CordicStepsDef
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  qry_pkg::qry_vec_t   vec_in,
    input  qry_pkg::qry_side_t  side_in,
    output qry_pkg::qry_vec_t   vec_out,
    output qry_pkg::qry_side_t  side_out
);
    import qry_pkg::*;

    localparam int Steps = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;

    qry_vec_t  stage_reg [Steps];
    qry_side_t side_reg  [Steps];

    for (genvar i = 0; i < Steps; i++)
    begin : g_step
        qry_vec_t               cur, nxt;
        qry_side_t              cur_side;
        logic signed [VecW-1:0] xi, yi;

        if (i == 0)
        begin : g_first
            assign cur      = vec_in;
            assign cur_side = side_in;
        end
        else
        begin : g_rest
            assign cur      = stage_reg[i-1];
            assign cur_side = side_reg[i-1];
        end

        assign xi = cur.x;
        assign yi = cur.y;

        // Rotate toward the positive X axis; the shifts floor.
        always_comb
        begin
            nxt = cur;
            if (!yi[VecW-1])
            begin
                nxt.x   = xi + (yi >>> i);
                nxt.y   = yi - (xi >>> i);
                nxt.acc = cur.acc + atan_entry(i);
            end
            else
            begin
                nxt.x   = xi - (yi >>> i);
                nxt.y   = yi + (xi >>> i);
                nxt.acc = cur.acc - atan_entry(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[i] <= '0;
            end
            else if (adv)
            begin
                side_reg[i] <= cur_side;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stage_reg[i] <= nxt;
            end
        end
    end

    assign vec_out  = stage_reg[Steps-1];
    assign side_out = side_reg[Steps-1];

    // X never shrinks once folded into the right half plane.
    assert property (@(posedge clk) disable iff (!rst_n)
        (side_out.valid && !vec_out.zero) |-> !vec_out.x[VecW-1])
        else $error("qry_cordic: X went negative");

endmodule

### hdl/qry_diff.sv
// Heading rounding, reference hold and scaled turn magnitude with result register.
`timescale 1ns / 1ps

module qry_diff (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  qry_pkg::qry_vec_t             vec_in,
    input  qry_pkg::qry_side_t            side_in,
    output logic                          out_valid,
    output logic [qry_pkg::TurnW-1:0]     turn_angle,
    output logic [qry_pkg::TimeW-1:0]     out_time_us
);
    import qry_pkg::*;

    logic [HeadW-1:0]  ref_reg, ref_next;
    logic              valid_reg;
    logic [TurnW-1:0]  turn_reg, turn_next;
    logic [TimeW-1:0]  time_reg;

    logic [AccW-1:0]   rounded;
    logic [HeadW-1:0]  head, ref_eff, delta;
    logic [MagW-1:0]   mag;
    logic [ScaleW-1:0] scaled;

    always_comb
    begin
        rounded = vec_in.acc + RoundHead;
        head    = vec_in.zero ? '0 : rounded[AccW-1 -: HeadW];
        // A reference beat compares against its own heading.
        ref_eff = side_in.set_ref ? head : ref_reg;
        delta   = head - ref_eff;
        // Half a turn counts as positive.
        mag     = delta[HeadW-1] ? (FullTurn - {1'b0, delta}) : {1'b0, delta};
        scaled  = (ScaleW'(mag) * DegScale) + RoundTurn;
        turn_next = scaled[TurnShift +: TurnW];
        ref_next  = (adv && side_in.valid && side_in.set_ref) ? head : ref_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            ref_reg <= ref_next;
            if (adv)
            begin
                valid_reg <= side_in.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            turn_reg <= turn_next;
            time_reg <= side_in.time_us;
        end
    end

    assign out_valid   = valid_reg;
    assign turn_angle  = turn_reg;
    assign out_time_us = time_reg;

    // A reference beat always reports no turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && side_in.valid && side_in.set_ref) |=> (turn_reg == '0))
        else $error("qry_diff: reference beat reported a turn");

    // Result never exceeds half a turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (turn_reg <= TurnMax))
        else $error("qry_diff: turn angle out of range");

    // The reference only moves on a delivered reference beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(adv && side_in.valid && side_in.set_ref) |=> $stable(ref_reg))
        else $error("qry_diff: reference changed without a reference beat");

endmodule

### hdl/quaternion_relative_yaw_top.sv
// Top level: quaternion to heading offset from a stored reference heading.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_stall  | q_w q_x q_y q_z time_us set_reference
//   out     | out_valid / out_stall| turn_angle out_time_us
//
// One beat enters per cycle when the output is not held. Each beat passes
// through the input register, product stage, sum and fold stage, one stage
// per CORDIC iteration, then the result register.
// Reset clears the valid bits and the reference heading (to zero).
// A stalled result freezes the whole pipeline; in_stall rises only then.
`timescale 1ns / 1ps

module quaternion_relative_yaw_top #(
    parameter int CORDIC_STEPS = qry_pkg::CordicStepsDef
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [qry_pkg::QW-1:0]  q_w,
    input  logic signed [qry_pkg::QW-1:0]  q_x,
    input  logic signed [qry_pkg::QW-1:0]  q_y,
    input  logic signed [qry_pkg::QW-1:0]  q_z,
    input  logic [qry_pkg::TimeW-1:0]      time_us,
    input  logic                           set_reference,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [qry_pkg::TurnW-1:0]      turn_angle,
    output logic [qry_pkg::TimeW-1:0]      out_time_us
);
    import qry_pkg::*;

    logic                   adv;
    logic signed [QW-1:0]   qw_reg, qx_reg, qy_reg, qz_reg;
    qry_side_t              in_side_reg, in_side_next;
    qry_vec_t               axis_vec, cordic_vec;
    qry_side_t              axis_side, cordic_side;

    // Advance every stage unless a finished result is being held.
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    always_comb
    begin
        in_side_next.valid   = in_valid;
        in_side_next.set_ref = set_reference;
        in_side_next.time_us = time_us;
    end

    // Input register: capture the beat, or a bubble when none is offered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_side_reg <= '0;
        end
        else if (adv)
        begin
            in_side_reg <= in_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qw_reg <= q_w;
            qx_reg <= q_x;
            qy_reg <= q_y;
            qz_reg <= q_z;
        end
    end

    // Horizontal projection of the body X axis.
    qry_axis u_axis (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .q_w      (qw_reg),
        .q_x      (qx_reg),
        .q_y      (qy_reg),
        .q_z      (qz_reg),
        .side_in  (in_side_reg),
        .vec_out  (axis_vec),
        .side_out (axis_side)
    );

    // Heading by vectoring CORDIC.
    qry_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vec_in   (axis_vec),
        .side_in  (axis_side),
        .vec_out  (cordic_vec),
        .side_out (cordic_side)
    );

    // Reference hold, wrapped difference and degree scaling.
    qry_diff u_diff (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .vec_in      (cordic_vec),
        .side_in     (cordic_side),
        .out_valid   (out_valid),
        .turn_angle  (turn_angle),
        .out_time_us (out_time_us)
    );

endmodule

### tb/quaternion_relative_yaw_top_test.sv
// Testbench for quaternion_relative_yaw_top: directed corners, then random IMU swings.
`timescale 1ns / 1ps

module quaternion_relative_yaw_top_test;

    import qry_pkg::*;

    // Keep the pipeline depth in step with the instance below.
    localparam int CordicSteps = 16;
    localparam int UsedSteps   = (CordicSteps > AtanLen) ? AtanLen : CordicSteps;
    localparam int PipeDepth   = UsedSteps + 4;

    // Random item budget: the swing test stops near SwingItems, the full-rate test near ItemTarget.
    localparam int SwingItems  = 650;
    localparam int ItemTarget  = 850;

    // Expected-result ring, far deeper than the beats the pipeline can hold.
    localparam int ExpAw       = 6;
    localparam int ExpDepth    = 2 ** ExpAw;

    // Q3.30 one, and the half-turn seed of the angle accumulator.
    localparam longint          AxisOne    = 64'sd1073741824;
    localparam logic [31:0]     AngleHalf  = 32'h8000_0000;
    localparam logic [31:0]     AngleRound = 32'h0000_8000;

    // One result beat as the block delivers it.
    typedef struct packed {
        logic [TurnW-1:0] turn;
        logic [TimeW-1:0] stamp;
    } yaw_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [QW-1:0]   q_w;
    logic signed [QW-1:0]   q_x;
    logic signed [QW-1:0]   q_y;
    logic signed [QW-1:0]   q_z;
    logic [TimeW-1:0]       time_us;
    logic                   set_reference;
    logic                   out_valid;
    logic                   out_stall;
    logic [TurnW-1:0]       turn_angle;
    logic [TimeW-1:0]       out_time_us;

    // arctan(2^-i) on the 2^32 = 360 degree scale, one entry per CORDIC rotation.
    logic [31:0] arctan_step [0:23] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    // Predictor state: the stored reference heading, cleared by reset.
    logic [HeadW-1:0] ref_heading;

    // Turn angles still owed by the block; the oldest sits at exp_rd.
    yaw_result_t      expect_buf [ExpDepth];
    int               exp_wr;
    int               exp_rd;

    int               mismatches;
    int               sent_count;
    bit               tx_burst;     // sender skips its random gaps
    bit               rx_burst;     // receiver skips its random stalls
    logic [TimeW-1:0] clock_us;     // running IMU timestamp for the swing tests

    quaternion_relative_yaw_top #(
        .CORDIC_STEPS (CordicSteps)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .q_w           (q_w),
        .q_x           (q_x),
        .q_y           (q_y),
        .q_z           (q_z),
        .time_us       (time_us),
        .set_reference (set_reference),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .turn_angle    (turn_angle),
        .out_time_us   (out_time_us)
    );

    // 2 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Heading of the horizontal axis (ax, ay) as a 16-bit binary angle.
    // Vectoring CORDIC: rotate the vector onto +X and sum the rotations.
    // Arithmetic shifts on longint floor toward minus infinity, as required.
    function automatic logic [HeadW-1:0] axis_heading(input longint ax, input longint ay);
        logic [31:0] angle;
        longint      dx;
        longint      dy;
        angle = '0;
        // Degenerate axis (pointing straight up or down): heading 0.
        if (ax == 0 && ay == 0)
            return '0;
        // Left half plane: flip the vector and start from 180 degrees.
        if (ax < 0)
        begin
            ax    = -ax;
            ay    = -ay;
            angle = AngleHalf;
        end
        for (int i = 0; i < UsedSteps; i++)
        begin
            dx = ay >>> i;
            dy = ax >>> i;
            if (ay >= 0)
            begin
                ax    = ax + dx;
                ay    = ay - dy;
                angle = angle + arctan_step[i];
            end
            else
            begin
                ax    = ax - dx;
                ay    = ay + dy;
                angle = angle - arctan_step[i];
            end
        end
        // Round the 32-bit accumulator to the 16-bit heading.
        angle = angle + AngleRound;
        return angle[31:16];
    endfunction

    // Expected result for one accepted sample; updates the reference first when flagged.
    function automatic yaw_result_t yaw_turn_of(input logic signed [QW-1:0] w,
                                                input logic signed [QW-1:0] x,
                                                input logic signed [QW-1:0] y,
                                                input logic signed [QW-1:0] z,
                                                input logic [TimeW-1:0]     stamp,
                                                input logic                 mark_ref);
        longint           sw;
        longint           sx;
        longint           sy;
        longint           sz;
        longint           ax;
        longint           ay;
        logic [HeadW-1:0] heading;
        logic [HeadW-1:0] delta;
        int unsigned      mag;
        int unsigned      scaled;
        yaw_result_t      res;
        sw = w;
        sx = x;
        sy = y;
        sz = z;
        // Body X axis in the world frame, horizontal part only, Q3.30.
        ax = AxisOne - 2 * (sy * sy + sz * sz);
        ay = 2 * (sx * sy + sw * sz);
        heading = axis_heading(ax, ay);
        if (mark_ref)
            ref_heading = heading;
        // Wrapped difference; the exact half turn counts as +180 degrees.
        delta = heading - ref_heading;
        if (delta[HeadW-1])
            mag = 32'h1_0000 - delta;
        else
            mag = delta;
        // 180/32768 degrees per unit, 64 units per degree: * 45 / 128, round half up.
        scaled    = (mag * 45 + 64) >> 7;
        res.turn  = scaled[TurnW-1:0];
        res.stamp = stamp;
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------

    // Print one line per mismatch and count every one.
    task automatic flag_mismatch(input string what, input longint want, input longint got);
        $display("mismatch at %0t: %s want %0d got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // Compare every accepted result beat against the oldest pending turn.
    // Outputs are registered, so sampling here sees the pre-edge values.
    always @(posedge clk)
    begin : check_beat
        yaw_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_wr == exp_rd)
                flag_mismatch("unexpected result, turn_angle", 0, turn_angle);
            else
            begin
                want = expect_buf[exp_rd[ExpAw-1:0]];
                exp_rd++;
                if (turn_angle !== want.turn)
                    flag_mismatch("turn_angle", want.turn, turn_angle);
                if (out_time_us !== want.stamp)
                    flag_mismatch("out_time_us", want.stamp, out_time_us);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result side: may stall before each beat, unless bursting
    // ---------------------------------------------------------------------

    initial
    begin : result_sink
        int hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = rx_burst ? 0 : $urandom_range(0, 7);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            // Hold the stall low until one beat goes through.
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // ---------------------------------------------------------------------
    // Sample side
    // ---------------------------------------------------------------------

    // Send one sample: idle for a random gap unless bursting, then present it and hold it until accepted.
    // Called right after a rising edge; valid gets a single assignment per edge.
    task automatic send_sample(input logic signed [QW-1:0] w,
                               input logic signed [QW-1:0] x,
                               input logic signed [QW-1:0] y,
                               input logic signed [QW-1:0] z,
                               input logic [TimeW-1:0]     stamp,
                               input logic                 mark_ref);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        q_w           <= w;
        q_x           <= x;
        q_y           <= y;
        q_z           <= z;
        time_us       <= stamp;
        set_reference <= mark_ref;
        do
            @(posedge clk);
        while (in_stall);
        expect_buf[exp_wr[ExpAw-1:0]] = yaw_turn_of(w, x, y, z, stamp, mark_ref);
        exp_wr++;
        sent_count++;
    endtask

    // Drop valid and wait until every pending turn has come out, then let the
    // pipeline run empty.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (PipeDepth + 4) @(posedge clk);
    endtask

    // Draw a unit quaternion: random yaw, tilt components up to +/- tilt before scaling.
    task automatic draw_orientation(input int tilt,
                                    output logic signed [QW-1:0] w,
                                    output logic signed [QW-1:0] x,
                                    output logic signed [QW-1:0] y,
                                    output logic signed [QW-1:0] z);
        real cw;
        real cx;
        real cy;
        real cz;
        real norm;
        cw = $itor($urandom_range(0, 65535)) - 32768.0;
        cz = $itor($urandom_range(0, 65535)) - 32768.0;
        cx = $itor($urandom_range(0, 2 * tilt)) - $itor(tilt);
        cy = $itor($urandom_range(0, 2 * tilt)) - $itor(tilt);
        norm = $sqrt(cw * cw + cx * cx + cy * cy + cz * cz);
        if (norm < 1.0)
            norm = 1.0;
        w = QW'($rtoi(cw * 32767.0 / norm));
        x = QW'($rtoi(cx * 32767.0 / norm));
        y = QW'($rtoi(cy * 32767.0 / norm));
        z = QW'($rtoi(cz * 32767.0 / norm));
    endtask

    // One recorded swing: a reference (address) sample, then len samples at about 1 kHz.
    // A noisy segment is raw bus garbage instead: random fields, stray reference flags.
    task automatic send_segment(input int len, input bit noisy);
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
        logic [TimeW-1:0]     raw_stamp;
        int                   tilt;
        // Mostly near-level club swings, sometimes any attitude at all.
        tilt = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(0, 4000);
        if (!noisy)
        begin
            draw_orientation(tilt, w, x, y, z);
            send_sample(w, x, y, z, clock_us, 1'b1);
        end
        repeat (len)
        begin
            clock_us = clock_us + 1000 + $urandom_range(0, 31);
            if (noisy)
            begin
                w         = QW'($urandom);
                x         = QW'($urandom);
                y         = QW'($urandom);
                z         = QW'($urandom);
                raw_stamp = $urandom;
                send_sample(w, x, y, z, raw_stamp, $urandom_range(0, 7) == 0);
            end
            else
            begin
                draw_orientation(tilt, w, x, y, z);
                send_sample(w, x, y, z, clock_us, 1'b0);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Right after reset the reference is zero: headings come out as absolute turns.
    task automatic test_headings_without_reference();
        send_sample(16'sd32767,  16'sd0,      16'sd0,      16'sd0,      32'h0000_0000, 1'b0);
        // Zero quaternion: axis stays on +X.
        send_sample(16'sd0,      16'sd0,      16'sd0,      16'sd0,      32'hFFFF_FFFF, 1'b0);
        send_sample(16'sd23170,  16'sd0,      16'sd0,      16'sd23170,  32'd1,         1'b0);
        send_sample(16'sd23170,  16'sd0,      16'sd0,     -16'sd23170,  32'd2,         1'b0);
        // Left half plane, axis on -X exactly.
        send_sample(16'sd0,      16'sd0,      16'sd0,      16'sd32767,  32'd3,         1'b0);
        // Axis vertical: horizontal projection vanishes.
        send_sample(16'sd0,      16'sd0,      16'sd16384,  16'sd16384,  32'd4,         1'b0);
        // Non-unit extremes, no normalization.
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 32'd5,         1'b0);
        send_sample(16'sd32767,  16'sd32767,  16'sd32767,  16'sd32767,  32'd6,         1'b0);
        send_sample(-16'sd32768, 16'sd0,      16'sd0,      16'sd32767,  32'd7,         1'b0);
        send_sample(16'sd0,      16'sd32767,  16'sd32767,  16'sd0,      32'd8,         1'b0);
    endtask

    // Reference samples: own turn is zero, later turns measured from them,
    // including the exact half turn and a reference on a vertical axis.
    task automatic test_reference_capture();
        send_sample(16'sd23170,  16'sd0,      16'sd0,      16'sd23170,  32'd1000,      1'b1);
        send_sample(16'sd32767,  16'sd0,      16'sd0,      16'sd0,      32'd2000,      1'b0);
        send_sample(16'sd23170,  16'sd0,      16'sd0,     -16'sd23170,  32'd3000,      1'b0);
        send_sample(16'sd0,      16'sd0,      16'sd0,      16'sd32767,  32'd4000,      1'b1);
        send_sample(16'sd32767,  16'sd0,      16'sd0,      16'sd0,      32'd5000,      1'b0);
        send_sample(16'sd0,      16'sd0,      16'sd16384,  16'sd16384,  32'd6000,      1'b0);
        send_sample(16'sd0,      16'sd0,      16'sd16384,  16'sd16384,  32'd7000,      1'b1);
        send_sample(-16'sd32768, 16'sd0,      16'sd0,      16'sd0,      32'd8000,      1'b0);
        send_sample(16'sd21845, -16'sd21846,  16'sd10922, -16'sd10923,  32'hAAAA_AAAA, 1'b0);
        send_sample(-16'sd21846, 16'sd21845, -16'sd10923,  16'sd10922,  32'h5555_5555, 1'b1);
        // Pause the sender until the pipeline has drained.
        wait_all_results();
    endtask

    // Random swings with random gaps and stalls, bursts now and then,
    // noisy segments mixed in, and a full drain every few segments.
    task automatic test_recorded_swings();
        int seg;
        seg = 0;
        while (sent_count < SwingItems)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            send_segment($urandom_range(5, 40), $urandom_range(0, 5) == 0);
            seg++;
            if (seg % 4 == 0)
                wait_all_results();
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // Back-to-back beats on both sides to exercise one beat per cycle.
    task automatic test_full_rate();
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        while (sent_count < ItemTarget)
            send_segment($urandom_range(20, 60), 1'b0);
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        q_w           <= '0;
        q_x           <= '0;
        q_y           <= '0;
        q_z           <= '0;
        time_us       <= '0;
        set_reference <= 1'b0;
        ref_heading    = '0;
        exp_wr         = 0;
        exp_rd         = 0;
        mismatches     = 0;
        sent_count     = 0;
        tx_burst       = 1'b0;
        rx_burst       = 1'b0;
        clock_us       = $urandom;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_headings_without_reference();
        test_reference_capture();
        test_recorded_swings();
        test_full_rate();

        // Let every pending turn come out, then give the pipeline time to
        // show any stray beat.
        wait_all_results();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
